// ----- sv/pts_pkg.sv -----
// Shared types, codes and helpers for the polynomial term store.
// Used by pts_ctrl, pts_dp and the top level; depends on nothing.
package pts_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] FN_ADD    = 3'd0;
    localparam logic [2:0] FN_ASSIGN = 3'd1;
    localparam logic [2:0] FN_QUERY  = 3'd2;
    localparam logic [2:0] FN_EVAL   = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    localparam logic [1:0] IDX_ZERO = 2'd0;
    localparam logic [1:0] IDX_HI   = 2'd1;
    localparam logic [1:0] IDX_KP1  = 2'd2;
    localparam logic [1:0] IDX_KM1  = 2'd3;

    localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         exponent;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         next_exponent;
        logic [5:0]         poly_degree;
        logic [6:0]         term_count;
        logic               range_error;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic       capture;
        logic       addr_idx;
        logic       scan_rd;
        logic       wr_update;
        logic       wr_zero;
        logic       tbl_clear;
        logic       idx_load;
        logic [1:0] idx_src;
        logic       idx_inc;
        logic       idx_dec;
        logic       acc_load_rd;
        logic       prod_load;
        logic       acc_step;
        logic       hi_load_hit;
        logic       next_load_hit;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       rerr;
        logic       add_nop;
        logic       cnt_zero;
        logic       need_down;
        logic       k_ge_hi;
        logic       hit;
        logic       idx_zero;
        logic       idx_last;
        logic       out_free;
    } sts_t;

    // {clipped, value}: clip a signed value to the Q16.16 range
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > Q_MAX) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < Q_MIN) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ----- sv/pts_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/pts_ctrl.sv -----
// Control state machine of the polynomial term store.
// Depends on pts_pkg; drives the datapath through cmd_t, reads sts_t.
module pts_ctrl import pts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_WRITE = 4'd3;
    localparam logic [3:0] S_SDN   = 4'd4;
    localparam logic [3:0] S_QRD   = 4'd5;
    localparam logic [3:0] S_SUP   = 4'd6;
    localparam logic [3:0] S_EMUL  = 4'd7;
    localparam logic [3:0] S_EADD  = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.addr_idx = 1'b1;
                cmd.wr_zero  = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                if (sts.rerr) begin
                    state_next = S_DONE;
                end else begin
                    unique case (sts.func) inside
                        FN_ADD, FN_ASSIGN: begin
                            state_next = sts.add_nop ? S_DONE : S_WRITE;
                        end
                        FN_QUERY: begin
                            state_next = S_QRD;
                        end
                        FN_EVAL: begin
                            if (sts.cnt_zero) begin
                                state_next = S_DONE;
                            end else begin
                                cmd.idx_load = 1'b1;
                                cmd.idx_src  = IDX_HI;
                                state_next   = S_EMUL;
                            end
                        end
                        FN_CLEAR: begin
                            cmd.idx_load = 1'b1;
                            cmd.idx_src  = IDX_ZERO;
                            state_next   = S_CLR;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                cmd.wr_update = 1'b1;
                if (sts.need_down) begin
                    cmd.idx_load = 1'b1;
                    cmd.idx_src  = IDX_KM1;
                    state_next   = S_SDN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SDN: begin
                cmd.addr_idx = 1'b1;
                cmd.scan_rd  = 1'b1;
                cmd.idx_dec  = 1'b1;
                if (sts.hit) begin
                    cmd.hi_load_hit = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_QRD: begin
                cmd.acc_load_rd = 1'b1;
                if (sts.k_ge_hi) begin
                    state_next = S_DONE;
                end else begin
                    cmd.idx_load = 1'b1;
                    cmd.idx_src  = IDX_KP1;
                    state_next   = S_SUP;
                end
            end
            S_SUP: begin
                cmd.addr_idx = 1'b1;
                cmd.scan_rd  = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.hit) begin
                    cmd.next_load_hit = 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_EMUL: begin
                cmd.addr_idx  = 1'b1;
                cmd.prod_load = 1'b1;
                state_next    = S_EADD;
            end
            S_EADD: begin
                cmd.acc_step = 1'b1;
                if (sts.idx_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_EMUL;
                end
            end
            S_CLR: begin
                cmd.addr_idx = 1'b1;
                cmd.wr_zero  = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (sts.idx_last) begin
                    cmd.tbl_clear = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/pts_dp.sv -----
// Datapath of the polynomial term store: coefficient RAM, counters,
// Horner multiply-add and the output register. Depends on pts_pkg, pts_ram.
module pts_dp import pts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_data,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

    in_word_t           item_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      nxt_reg;
    logic [AW-1:0]      addr_q_reg;
    logic               scan_vld_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic               sat_reg;
    logic               out_vld_reg;
    out_word_t          out_reg;

    logic [AW-1:0]      k;
    logic [AW-1:0]      raddr, waddr;
    logic [31:0]        rd_data;
    logic [31:0]        wdata;
    logic               uses_k, rerr_w, is_add;
    logic [32:0]        add_sat;
    logic [31:0]        new_coef;
    logic               old_nz, new_nz;
    logic [CW-1:0]      cnt_upd;
    logic signed [63:0] rnd;
    logic [32:0]        rnd_sat, step_sat;

    assign k      = AW'(item_reg.exponent);
    assign uses_k = (item_reg.func == FN_ADD) || (item_reg.func == FN_ASSIGN)
                 || (item_reg.func == FN_QUERY);
    assign rerr_w = uses_k && (32'(item_reg.exponent) >= 32'(DEPTH));
    assign is_add = (item_reg.func == FN_ADD);

    assign raddr = cmd.addr_idx ? idx_reg : k;
    assign waddr = cmd.wr_zero ? idx_reg : k;
    assign wdata = cmd.wr_zero ? 32'd0 : new_coef;

    pts_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_zero | cmd.wr_update),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign add_sat  = sat32({{32{rd_data[31]}}, rd_data}
                          + {{32{item_reg.value[31]}}, item_reg.value});
    assign new_coef = is_add ? add_sat[31:0] : item_reg.value;
    assign old_nz   = (rd_data != 32'd0);
    assign new_nz   = (new_coef != 32'd0);
    assign cnt_upd  = cnt_reg + CW'(new_nz) - CW'(old_nz);

    assign rnd      = {{16{prod_reg[63]}}, prod_reg[63:16]} + 64'(prod_reg[15]);
    assign rnd_sat  = sat32(rnd);
    assign step_sat = sat32({{32{rnd_sat[31]}}, rnd_sat[31:0]}
                          + {{32{rd_data[31]}}, rd_data});

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_load) begin
            case (cmd.idx_src)
                IDX_ZERO: idx_next = '0;
                IDX_HI:   idx_next = hi_reg;
                IDX_KP1:  idx_next = k + AW'(1);
                default:  idx_next = k - AW'(1);
            endcase
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + AW'(1);
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - AW'(1);
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        hi_next  = hi_reg;
        if (cmd.tbl_clear) begin
            cnt_next = '0;
            hi_next  = '0;
        end else if (cmd.wr_update) begin
            cnt_next = cnt_upd;
            if (new_nz && (cnt_reg == '0 || k > hi_reg)) begin
                hi_next = k;
            end else if (cnt_upd == '0) begin
                hi_next = '0;
            end
        end else if (cmd.hi_load_hit) begin
            hi_next = addr_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            cnt_reg      <= '0;
            hi_reg       <= '0;
            scan_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            hi_reg       <= hi_next;
            scan_vld_reg <= cmd.scan_rd;
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_q_reg <= raddr;
        if (cmd.capture) begin
            item_reg <= s_data;
            acc_reg  <= '0;
            nxt_reg  <= '0;
            sat_reg  <= 1'b0;
        end else begin
            if (cmd.acc_load_rd) begin
                acc_reg <= rd_data;
            end else if (cmd.acc_step) begin
                acc_reg <= step_sat[31:0];
                sat_reg <= sat_reg | rnd_sat[32] | step_sat[32];
            end
            if (cmd.wr_update && is_add && add_sat[32]) begin
                sat_reg <= 1'b1;
            end
            if (cmd.next_load_hit) begin
                nxt_reg <= addr_q_reg;
            end
        end
        if (cmd.prod_load) begin
            prod_reg <= 64'(acc_reg) * 64'(item_reg.value);
        end
        if (cmd.out_load) begin
            out_reg.result_value  <= acc_reg;
            out_reg.next_exponent <= 6'(nxt_reg);
            out_reg.poly_degree   <= 6'(hi_reg);
            out_reg.term_count    <= 7'(cnt_reg);
            out_reg.range_error   <= rerr_w;
            out_reg.saturated     <= sat_reg;
        end
    end

    assign sts.func      = item_reg.func;
    assign sts.rerr      = rerr_w;
    assign sts.add_nop   = is_add && (item_reg.value == 32'sd0);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.need_down = !new_nz && old_nz && (k == hi_reg) && (cnt_upd != '0);
    assign sts.k_ge_hi   = (k >= hi_reg);
    assign sts.hit       = scan_vld_reg && (rd_data != 32'd0);
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_last  = (idx_reg == IDX_LAST);
    assign sts.out_free  = !out_vld_reg || m_ready;

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("term count above table depth");

    a_empty_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (hi_reg == '0))
        else $error("empty table with nonzero degree");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_vld_reg || m_ready))
        else $error("result word overwritten");

    a_out_vld: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_vld_reg)
        else $error("loaded result word not presented");

endmodule

// ----- sv/polynomial_term_store.sv -----
// Add/assign writes the new coefficient (an add of zero, an out-of-range
// exponent or an unused code skip to the result), then a downward degree scan
// (one entry per cycle) runs when the top term drops out; query reads the term
// and scans upward to the next present term; evaluate runs a Horner multiply
// then add per term from the degree down; clear writes zeros to every entry.
// One word at a time; the next word is taken while a result waits.
// Reset (aresetn, synchronous, low) sweeps zeros through the RAM.
module polynomial_term_store import pts_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    cmd_t cmd;
    sts_t sts;

    pts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pts_dp #(.DEPTH(DEPTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
